[src/bfd_pkg.sv]
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared constants and types for the basic factor dictionary.
// ----------------------------------------------------------------------------
package bfd_pkg;
  localparam int MAX_TEXT_DEF   = 1024;
  localparam int MAX_LEVELS_DEF = 10;

  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_ID   = 2'd1,
    KIND_SUCC = 2'd2,
    KIND_PRED = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RANK,
    ST_L0_RD,
    ST_L0_WR,
    ST_CLR,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_PFX_RD,
    ST_PFX_WR,
    ST_PLC_RD,
    ST_PLC_WR,
    ST_REN_RD,
    ST_REN_WR,
    ST_NEXT,
    ST_Q_RD,
    ST_Q_CHK,
    ST_OUT
  } state_t;

  // which of the three sort/rename passes is running
  typedef enum logic [1:0] {
    PASS_SECOND,
    PASS_FIRST,
    PASS_RENAME
  } pass_t;
endpackage

[src/bfd_if.sv]
// ----------------------------------------------------------------------------
// bfd_in_if / bfd_out_if
// Valid/ready channels for load/query beats and result beats.
// ----------------------------------------------------------------------------
interface bfd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  text_byte;
  logic        final_byte;
  logic [9:0]  position;
  logic [10:0] factor_length;
  logic [9:0]  factor_id;
  modport source (output valid, kind, text_byte, final_byte, position,
                  factor_length, factor_id, input ready);
  modport sink (input valid, kind, text_byte, final_byte, position,
                factor_length, factor_id, output ready);
endinterface

interface bfd_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] value;
  logic       found;
  logic       error;
  modport source (output valid, value, found, error, input ready);
  modport sink (input valid, value, found, error, output ready);
endinterface

[src/basic_factor_dictionary_core.sv]
// ----------------------------------------------------------------------------
// basic_factor_dictionary_core
// Loads a text, builds prefix-doubling factor ids in memory, answers queries.
// ----------------------------------------------------------------------------
// channel | dir | content
// in      | in  | kind, text_byte, final_byte, position, factor_length, factor_id
// out     | out | value, found, error (one beat per query, none per load)
//
// A final load beat runs the build: ranking of the 256 byte values, then
// level 0, then a counting-sort and rename round per further level.
// A succ/pred query scans one position at a time until the id matches or
// the scan runs out of room; an error query skips the scan.
// Reset is synchronous; memories hold no reset.
// A stalled result holds in_ch.ready low until the result beat is taken.
module basic_factor_dictionary_core #(
  parameter int MAX_TEXT   = bfd_pkg::MAX_TEXT_DEF,
  parameter int MAX_LEVELS = bfd_pkg::MAX_LEVELS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  bfd_in_if.sink    in_ch,
  bfd_out_if.source out_ch
);
  import bfd_pkg::*;

  localparam int AW = $clog2(MAX_TEXT);
  localparam int NW = AW + 1;
  localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int LV = LW + 1;

  // memories
  logic [7:0]    text_mem [MAX_TEXT];
  logic [AW-1:0] ids_mem  [MAX_LEVELS*MAX_TEXT];
  logic [AW-1:0] ord2_mem [MAX_TEXT];
  logic [AW-1:0] ord1_mem [MAX_TEXT];
  logic [NW-1:0] bkt_mem  [MAX_TEXT+2];
  logic [255:0]  seen_r;

  state_t st_r, st_nxt;
  pass_t  pass_r;
  logic [NW-1:0] len_r;
  logic [LV-1:0] lvls_r;
  logic          built_r;
  logic [NW:0]   i_r;      // general loop index
  logic [NW:0]   cnt_r;    // number of ids at current level
  logic [NW-1:0] half_r;
  logic [NW-1:0] acc_r, cur_r, pa_r, pb_r;
  logic [8:0]    rk_i_r;
  logic [9:0]    rank_r [256];
  logic [9:0]    rkcnt_r;
  logic [1:0]    sub_r;
  logic [NW-1:0] tmp_r, p_r;
  logic [AW-1:0] akey_r;
  // query
  logic [1:0]    qk_r;
  logic [AW-1:0] qpos_r, qid_r;
  logic [LW-1:0] qlvl_r;
  logic [9:0]    ov_r;
  logic          of_r, oe_r, ovld_r;

  // registered read ports
  logic [7:0]    txt_q;
  logic [9:0]    rank_q;
  logic [AW-1:0] ids_q;
  logic [NW-1:0] bkt_q;
  logic [$clog2(MAX_LEVELS*MAX_TEXT)-1:0] ids_ra, ids_wa;
  logic [AW-1:0] ids_wd;
  logic          ids_we;
  logic          scan_more;

  function automatic logic [3:0] top_bit(input logic [10:0] v);
    logic [3:0] r;
    r = '0;
    for (int k = 1; k < 11; k++) if (v[k]) r = 4'(k);
    return r;
  endfunction

  function automatic logic [$clog2(MAX_LEVELS*MAX_TEXT)-1:0] ida(
      input logic [LW-1:0] l, input logic [NW:0] p);
    return ($clog2(MAX_LEVELS*MAX_TEXT))'(l * MAX_TEXT + p[AW-1:0]);
  endfunction

  assign in_ch.ready  = (st_r == ST_IDLE) && !ovld_r;
  assign out_ch.valid = ovld_r;
  assign out_ch.value = ov_r;
  assign out_ch.found = of_r;
  assign out_ch.error = oe_r;

  wire acc = in_ch.valid && in_ch.ready;
  wire [LW-1:0] clvl = lvls_r[LW-1:0];
  wire [NW:0]   ppos = {1'b0, p_r} + {1'b0, half_r};

  // succ/pred moves on while the id differs and the scan has room
  assign scan_more = (kind_t'(qk_r) != KIND_ID) && (ids_q != qid_r) &&
                     ((kind_t'(qk_r) == KIND_SUCC && 32'(qpos_r) + 1 < 32'(len_r)) ||
                      (kind_t'(qk_r) == KIND_PRED && qpos_r != '0));

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (acc) st_nxt = (kind_t'(in_ch.kind) == KIND_LOAD)
                                   ? (in_ch.final_byte ? ST_RANK : ST_IDLE) : ST_Q_RD;
      ST_RANK:   if (rk_i_r == 9'd255) st_nxt = ST_L0_RD;
      ST_L0_RD:  st_nxt = (i_r >= (NW+1)'(len_r)) ? ST_NEXT : ST_L0_WR;
      ST_L0_WR:  st_nxt = (sub_r == 2'd1) ? ST_L0_RD : ST_L0_WR;
      ST_NEXT:   st_nxt = ((({1'b0, half_r} << 1) < (NW+1)'(len_r)) &&
                           (32'(lvls_r) + 1 < MAX_LEVELS)) ? ST_CLR : ST_IDLE;
      ST_CLR:    if (i_r > cnt_r + 1) st_nxt = (pass_r == PASS_RENAME) ? ST_REN_RD
                                               : ST_CNT_RD;
      ST_CNT_RD: st_nxt = (i_r >= (NW+1)'(len_r)) ? ST_PFX_RD : ST_CNT_WR;
      ST_CNT_WR: st_nxt = (sub_r == 2'd2) ? ST_CNT_RD : ST_CNT_WR;
      ST_PFX_RD: st_nxt = (i_r > cnt_r + 1) ? ST_PLC_RD : ST_PFX_WR;
      ST_PFX_WR: st_nxt = ST_PFX_RD;
      ST_PLC_RD: st_nxt = (i_r >= (NW+1)'(len_r)) ?
                          (pass_r == PASS_SECOND ? ST_CLR : ST_REN_RD) : ST_PLC_WR;
      ST_PLC_WR: st_nxt = (sub_r == 2'd3) ? ST_PLC_RD : ST_PLC_WR;
      ST_REN_RD: st_nxt = (i_r >= (NW+1)'(len_r)) ? ST_NEXT : ST_REN_WR;
      ST_REN_WR: st_nxt = (sub_r == 2'd3) ? ST_REN_RD : ST_REN_WR;
      ST_Q_RD:   st_nxt = oe_r ? ST_OUT : ST_Q_CHK;
      ST_Q_CHK:  st_nxt = scan_more ? ST_Q_RD : ST_OUT;
      ST_OUT:    st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // memories and datapath: one sequencer drives every port
  always_ff @(posedge clk) begin
    if (ids_we) ids_mem[ids_wa] <= ids_wd;
    ids_q <= ids_mem[ids_ra];
  end

  always_comb begin
    ids_we = 1'b0;
    ids_wa = ida(clvl, i_r);
    ids_wd = '0;
    ids_ra = ida(clvl, i_r);
    unique case (st_r)
      ST_L0_WR: begin
        ids_we = (sub_r == 2'd1);
        ids_wa = ida('0, i_r);
        ids_wd = AW'(rank_q);
      end
      ST_CNT_RD: ids_ra = ida(clvl, (pass_r == PASS_SECOND) ?
                              (NW+1)'(i_r + (NW+1)'(half_r)) : i_r);
      ST_CNT_WR, ST_REN_WR:
        ids_ra = (sub_r == 2'd0) ? ida(clvl, {1'b0, p_r}) : ida(clvl, ppos);
      ST_PLC_WR:
        ids_ra = (pass_r == PASS_SECOND) ? ida(clvl, ppos) : ida(clvl, {1'b0, p_r});
      ST_REN_RD: ids_ra = ida(clvl, i_r);
      ST_Q_RD, ST_Q_CHK: ids_ra = ida(qlvl_r, {2'b00, qpos_r});
      default: ;
    endcase
    if (st_r == ST_REN_WR && sub_r == 2'd3) begin
      ids_we = 1'b1;
      ids_wa = ida(clvl + LW'(1), {1'b0, p_r});
      ids_wd = AW'(cur_r);
    end
  end

  // second key of position p_r at current level, given the read of p+half
  wire [NW-1:0] skey = (ppos < (NW+1)'(len_r)) ? NW'(ids_q) : NW'(cnt_r);

  always_ff @(posedge clk) begin
    txt_q <= text_mem[i_r[AW-1:0]];
    if (st_r == ST_IDLE && acc && kind_t'(in_ch.kind) == KIND_LOAD &&
        (built_r ? 1'b1 : (32'(len_r) < MAX_TEXT)))
      text_mem[built_r ? '0 : len_r[AW-1:0]] <= in_ch.text_byte;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; len_r <= '0; lvls_r <= '0; built_r <= 1'b0; ovld_r <= 1'b0;
      seen_r <= '0;
      pass_r <= PASS_SECOND; i_r <= '0; sub_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (ovld_r && out_ch.ready) ovld_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (acc) begin
          if (kind_t'(in_ch.kind) == KIND_LOAD) begin
            if (built_r) begin
              // drop the old text: only this beat's letter is seen
              seen_r <= 256'(1) << in_ch.text_byte;
              built_r <= 1'b0; lvls_r <= '0;
              len_r <= NW'(1);
            end else if (32'(len_r) < MAX_TEXT) begin
              seen_r[in_ch.text_byte] <= 1'b1;
              len_r <= len_r + NW'(1);
            end
            rk_i_r <= '0; rkcnt_r <= '0;
          end else begin
            qk_r   <= in_ch.kind;
            qpos_r <= AW'(in_ch.position);
            qid_r  <= AW'(in_ch.factor_id);
            qlvl_r <= LW'(top_bit(in_ch.factor_length));
            ov_r <= '0; of_r <= 1'b0;
            oe_r <= !built_r || (32'(in_ch.position) >= 32'(len_r)) ||
                    (32'(top_bit(in_ch.factor_length)) > 32'(lvls_r)) ||
                    (32'(top_bit(in_ch.factor_length)) >= MAX_LEVELS);
          end
        end
        ST_RANK: begin
          rank_r[rk_i_r[7:0]] <= rkcnt_r;
          rkcnt_r <= rkcnt_r + 10'(seen_r[rk_i_r[7:0]]);
          rk_i_r <= rk_i_r + 9'd1;
          i_r <= '0; lvls_r <= '0; half_r <= NW'(1);
        end
        ST_L0_RD: begin
          cnt_r <= (NW+1)'(rkcnt_r);
          i_r <= (i_r >= (NW+1)'(len_r)) ? '0 : i_r;
          pass_r <= PASS_SECOND;
          sub_r <= 2'd0;
        end
        ST_L0_WR: begin
          // sub 0: rank read of the text byte; sub 1: level-0 write
          if (sub_r == 2'd0) begin
            rank_q <= rank_r[txt_q];
            sub_r <= 2'd1;
          end else i_r <= i_r + 1'b1;
        end
        ST_NEXT: begin
          if (st_nxt == ST_IDLE) built_r <= 1'b1;
          i_r <= '0; pass_r <= PASS_SECOND;
        end
        ST_CLR: begin
          if (i_r > cnt_r + 1) begin
            i_r <= '0;
            if (pass_r == PASS_RENAME) cur_r <= '0;
          end else begin
            bkt_mem[i_r[NW-1:0]] <= '0;
            i_r <= i_r + 1'b1;
          end
        end
        ST_CNT_RD: begin
          // sub 0: key taken from the read issued in CNT_RD; sub 1: bucket read; sub 2: write
          p_r <= i_r[NW-1:0];
          sub_r <= 2'd0;
          if (i_r >= (NW+1)'(len_r)) begin i_r <= (NW+1)'(1); acc_r <= '0; end
        end
        ST_CNT_WR: begin
          unique case (sub_r)
            2'd0: begin
              tmp_r <= (pass_r == PASS_SECOND)
                       ? (((i_r + (NW+1)'(half_r)) < (NW+1)'(len_r)) ? NW'(ids_q)
                                                                      : NW'(cnt_r))
                       : NW'(ids_q);
              sub_r <= 2'd1;
            end
            2'd1: begin bkt_q <= bkt_mem[tmp_r + NW'(1)]; sub_r <= 2'd2; end
            default: begin
              bkt_mem[tmp_r + NW'(1)] <= bkt_q + NW'(1);
              sub_r <= 2'd0; i_r <= i_r + 1'b1;
            end
          endcase
        end
        ST_PFX_RD: begin
          if (i_r > cnt_r + 1) i_r <= '0;
          else bkt_q <= bkt_mem[i_r[NW-1:0]];
          sub_r <= 2'd0;
        end
        ST_PFX_WR: begin
          bkt_mem[i_r[NW-1:0]] <= bkt_q + acc_r;
          acc_r <= bkt_q + acc_r;
          i_r <= i_r + 1'b1;
        end
        ST_PLC_RD: begin
          sub_r <= 2'd0;
          if (i_r >= (NW+1)'(len_r)) begin
            i_r <= '0;
            pass_r <= (pass_r == PASS_SECOND) ? PASS_FIRST : PASS_RENAME;
            cur_r <= '0;
          end else begin
            p_r <= (pass_r == PASS_SECOND) ? i_r[NW-1:0] : NW'(ord2_mem[i_r[AW-1:0]]);
          end
        end
        ST_PLC_WR: begin
          unique case (sub_r)
            2'd0: sub_r <= 2'd1;  // ids read of p or p+half issued
            2'd1: begin
              akey_r <= ids_q;
              tmp_r <= (pass_r == PASS_SECOND) ? skey : NW'(ids_q);
              sub_r <= 2'd2;
            end
            2'd2: begin bkt_q <= bkt_mem[tmp_r]; sub_r <= 2'd3; end
            default: begin
              bkt_mem[tmp_r] <= bkt_q + NW'(1);
              if (pass_r == PASS_SECOND) ord2_mem[bkt_q[AW-1:0]] <= p_r[AW-1:0];
              else                       ord1_mem[bkt_q[AW-1:0]] <= p_r[AW-1:0];
              i_r <= i_r + 1'b1;
            end
          endcase
        end
        ST_REN_RD: begin
          sub_r <= 2'd0;
          if (i_r >= (NW+1)'(len_r)) begin
            cnt_r <= (NW+1)'(cur_r) + 1'b1;
            lvls_r <= lvls_r + LV'(1);
            half_r <= half_r << 1;
          end else p_r <= NW'(ord1_mem[i_r[AW-1:0]]);
        end
        ST_REN_WR: begin
          unique case (sub_r)
            2'd0: sub_r <= 2'd1;
            2'd1: begin akey_r <= ids_q; sub_r <= 2'd2; end
            2'd2: begin
              if (i_r != '0 && (NW'(akey_r) != pa_r || skey != pb_r))
                cur_r <= cur_r + NW'(1);
              pa_r <= NW'(akey_r); pb_r <= skey;
              sub_r <= 2'd3;
            end
            default: i_r <= i_r + 1'b1;
          endcase
        end
        ST_Q_RD: ;
        ST_Q_CHK: begin
          // id: take the value; succ/pred: on a match take the position, else step it and loop through Q_RD
          if (kind_t'(qk_r) == KIND_ID) ov_r <= 10'(ids_q);
          else if (ids_q == qid_r) begin ov_r <= 10'(qpos_r); of_r <= 1'b1; end
          else if (scan_more)
            qpos_r <= (kind_t'(qk_r) == KIND_SUCC) ? qpos_r + AW'(1) : qpos_r - AW'(1);
        end
        ST_OUT: ovld_r <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule

[src/bfd_checker.sv]
// ----------------------------------------------------------------------------
// bfd_port_checker
// Port-level checks for the basic factor dictionary.
// ----------------------------------------------------------------------------
module bfd_port_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid, out_ready, out_found, out_error
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_error)) else $error("found with error");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accepting while result pending");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind basic_factor_dictionary_core bfd_port_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_found(out_ch.found), .out_error(out_ch.error)
);

[dv/bfd_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bfd_checker
// Watches the query and result channels, rebuilds the factor dictionary from
// the loaded text and compares every result beat with the predicted one.
// ----------------------------------------------------------------------------
module bfd_checker
  import bfd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  bfd_in_if.sink  in_mon,
  bfd_out_if.sink out_mon,
  output int      fail_count,
  output int      pending_count
);
  localparam int NT = MAX_TEXT_DEF;
  localparam int NL = MAX_LEVELS_DEF;

  typedef struct packed {
    logic [9:0] value;
    logic       found;
    logic       error;
  } answer_t;

  logic [7:0]  text_mem [NT];
  bit          seen_letter [256];
  int unsigned ids [NL][NT];
  int unsigned text_len;
  int unsigned lvl_count;
  bit          is_built;
  answer_t     answer_q[$];

  assign pending_count = answer_q.size();

  function automatic int unsigned pair_second(int unsigned lv, int unsigned p,
                                              int unsigned half, int unsigned cnt);
    return (p + half < text_len) ? ids[lv][p + half] : cnt;
  endfunction

  // counting-sort prefix doubling over the loaded text
  task automatic build_levels();
    int unsigned rank_of [256];
    int unsigned by_second [NT];
    int unsigned by_first [NT];
    int unsigned bucket [NT + 2];
    int unsigned cnt, lv, half, cur, pa, pb, a, s, p;
    cnt = 0;
    for (int c = 0; c < 256; c++) begin
      rank_of[c] = cnt;
      if (seen_letter[c]) cnt++;
    end
    for (int i = 0; i < text_len; i++) ids[0][i] = rank_of[text_mem[i]];
    lv = 0;
    half = 1;
    while (half * 2 < text_len && lv + 1 < NL) begin
      foreach (bucket[b]) bucket[b] = 0;
      for (int i = 0; i < text_len; i++)
        bucket[pair_second(lv, i, half, cnt) + 1]++;
      for (int b = 1; b <= cnt + 1; b++) bucket[b] += bucket[b - 1];
      for (int i = 0; i < text_len; i++)
        by_second[bucket[pair_second(lv, i, half, cnt)]++] = i;
      foreach (bucket[b]) bucket[b] = 0;
      for (int i = 0; i < text_len; i++) bucket[ids[lv][i] + 1]++;
      for (int b = 1; b <= cnt + 1; b++) bucket[b] += bucket[b - 1];
      for (int j = 0; j < text_len; j++) begin
        p = by_second[j];
        by_first[bucket[ids[lv][p]]++] = p;
      end
      cur = 0; pa = 0; pb = 0;
      for (int j = 0; j < text_len; j++) begin
        p = by_first[j];
        a = ids[lv][p];
        s = pair_second(lv, p, half, cnt);
        if (j > 0 && (a != pa || s != pb)) cur++;
        pa = a;
        pb = s;
        ids[lv + 1][p] = cur;
      end
      cnt = cur + 1;
      lv++;
      half *= 2;
    end
    lvl_count = lv;
    is_built = 1;
  endtask

  task automatic absorb_beat(kind_t k, logic [7:0] tb, logic fin, logic [9:0] pos,
                             logic [10:0] flen, logic [9:0] fid);
    answer_t ans;
    int unsigned lv, v;
    if (k == KIND_LOAD) begin
      if (is_built) begin
        is_built = 0;
        text_len = 0;
        lvl_count = 0;
        foreach (seen_letter[c]) seen_letter[c] = 0;
      end
      if (text_len < NT) begin
        text_mem[text_len] = tb;
        seen_letter[tb] = 1;
        text_len++;
      end
      if (fin) build_levels();
      return;
    end
    ans = '0;
    lv = 0;
    v = flen;
    while (v > 1) begin
      v >>= 1;
      lv++;
    end
    if (!is_built || pos >= text_len || lv > lvl_count || lv >= NL) begin
      ans.error = 1;
    end else if (k == KIND_ID) begin
      ans.value = ids[lv][pos];
    end else if (k == KIND_SUCC) begin
      for (int p = pos; p < text_len; p++)
        if (ids[lv][p] == fid) begin
          ans.value = p;
          ans.found = 1;
          break;
        end
    end else begin
      for (int p = pos; p >= 0; p--)
        if (ids[lv][p] == fid) begin
          ans.value = p;
          ans.found = 1;
          break;
        end
    end
    answer_q = {answer_q, ans};
  endtask

  always @(posedge clk) begin
    answer_t got, want;
    if (!rst_n) begin
      answer_q.delete();
      fail_count = 0;
      text_len = 0;
      lvl_count = 0;
      is_built = 0;
      foreach (seen_letter[c]) seen_letter[c] = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.value, out_mon.found, out_mon.error};
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %h", $time, got);
          fail_count++;
        end else begin
          want = answer_q.pop_front();
          if (got != want) begin
            $display({"%0t: result mismatch, expected value %0d found %0d error %0d,",
                      " got value %0d found %0d error %0d"},
                     $time, want.value, want.found, want.error,
                     got.value, got.found, got.error);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        absorb_beat(kind_t'(in_mon.kind), in_mon.text_byte, in_mon.final_byte,
                    in_mon.position, in_mon.factor_length, in_mon.factor_id);
    end
  end
endmodule

[dv/tb_basic_factor_dictionary_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_basic_factor_dictionary_core
// Loads random texts of varied size and alphabet, then fires id, successor
// and predecessor queries with random gaps in most phases and result back-pressure.
// ----------------------------------------------------------------------------
module tb_basic_factor_dictionary_core;
  import bfd_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  bit   stim_done;

  bfd_in_if  in_ch ();
  bfd_out_if out_ch ();

  basic_factor_dictionary_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  bfd_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch.sink),
    .out_mon       (out_ch.sink),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  int unsigned cur_len;

  // one beat: optional random gap, then hold until accepted
  task automatic send_beat(kind_t k, logic [7:0] tb, logic fin, logic [9:0] pos,
                           logic [10:0] flen, logic [9:0] fid, bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(15, 0) : 0;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1;
    in_ch.kind          <= k;
    in_ch.text_byte     <= tb;
    in_ch.final_byte    <= fin;
    in_ch.position      <= pos;
    in_ch.factor_length <= flen;
    in_ch.factor_id     <= fid;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic load_text(int unsigned len, int unsigned alpha, bit gaps);
    for (int i = 0; i < len; i++)
      send_beat(KIND_LOAD, (alpha >= 256) ? 8'($urandom) : 8'($urandom_range(alpha - 1, 0)),
                i == len - 1, 10'($urandom), 11'($urandom), 10'($urandom), gaps);
    cur_len = (len > MAX_TEXT_DEF) ? MAX_TEXT_DEF : len;
  endtask

  // mostly in-range positions, sane lengths and small ids; some noise
  task automatic send_query(bit gaps);
    kind_t       k;
    logic [9:0]  pos;
    logic [10:0] flen;
    logic [9:0]  fid;
    k = kind_t'($urandom_range(3, 1));
    pos = ($urandom_range(9, 0) == 0) ? 10'($urandom) : 10'($urandom_range(cur_len - 1, 0));
    flen = ($urandom_range(9, 0) == 0) ? 11'($urandom) : 11'($urandom_range(cur_len, 0));
    fid = ($urandom_range(4, 0) == 0) ? 10'($urandom) : 10'($urandom_range(cur_len, 0));
    send_beat(k, 8'($urandom), 1'($urandom), pos, flen, fid, gaps);
  endtask

  initial begin
    int unsigned len;
    bit          gaps;
    rst_n = 0;
    stim_done = 0;
    in_ch.valid = 0;
    in_ch.kind = KIND_LOAD;
    in_ch.text_byte = 0;
    in_ch.final_byte = 0;
    in_ch.position = 0;
    in_ch.factor_length = 0;
    in_ch.factor_id = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // directed: queries before any build
    send_beat(KIND_ID, 8'h00, 0, 10'd0, 11'd1, 10'd0, 0);
    send_beat(KIND_SUCC, 8'hff, 1, 10'd1023, 11'd2047, 10'd1023, 0);
    // single byte text, extreme byte values
    send_beat(KIND_LOAD, 8'hff, 1, 10'd1023, 11'd2047, 10'd1023, 0);
    cur_len = 1;
    send_beat(KIND_ID, 8'h00, 0, 10'd0, 11'd0, 10'd0, 0);
    send_beat(KIND_ID, 8'h00, 0, 10'd0, 11'd2, 10'd0, 0);
    send_beat(KIND_PRED, 8'h00, 0, 10'd0, 11'd1, 10'd0, 0);
    send_beat(KIND_SUCC, 8'h00, 0, 10'd1, 11'd1, 10'd0, 0);
    send_beat(KIND_LOAD, 8'h00, 0, 0, 0, 0, 0);
    send_beat(KIND_LOAD, 8'hff, 0, 0, 0, 0, 0);
    send_beat(KIND_LOAD, 8'h00, 1, 0, 0, 0, 0);
    cur_len = 3;
    send_beat(KIND_ID, 0, 0, 10'd2, 11'd2, 0, 0);
    send_beat(KIND_SUCC, 0, 0, 10'd0, 11'd1, 10'd1, 0);
    send_beat(KIND_PRED, 0, 0, 10'd2, 11'd1, 10'd1, 0);
    send_beat(KIND_PRED, 0, 0, 10'd2, 11'd1, 10'd1023, 0);
    send_beat(KIND_ID, 0, 0, 10'd0, 11'd4, 0, 0);
    // full overflowing text: level cap and dropped bytes
    load_text(1030, 2, 0);
    send_beat(KIND_ID, 0, 0, 10'd1023, 11'd1024, 0, 0);
    send_beat(KIND_SUCC, 0, 0, 10'd0, 11'd512, 10'd1023, 0);
    send_beat(KIND_PRED, 0, 0, 10'd1023, 11'd1023, 10'd0, 0);
    // random phases: short texts
    for (int ph = 0; ph < 6; ph++) begin
      gaps = (ph % 4) != 1;
      len = $urandom_range(40, 1);
      load_text(len, ($urandom_range(2, 0) == 0) ? 256 : $urandom_range(4, 1), gaps);
      repeat ($urandom_range(30, 10)) send_query(gaps);
    end
    in_ch.valid <= 0;
    stim_done = 1;
  end

  // result side: draw a wait for every result beat
  initial begin
    int unsigned gap;
    out_ch.ready = 0;
    @(posedge rst_n);
    forever begin
      gap = $urandom_range(15, 0);
      if (gap > 0) begin
        out_ch.ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  initial begin
    wait (stim_done);
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
